// File: src/srld_pkg.sv
package srld_pkg;

    // Event kinds carried by the req_type field.
    typedef enum logic [1:0] {
        EV_LINE     = 2'd0,
        EV_DEBOUNCE = 2'd1,
        EV_PWM      = 2'd2,
        EV_NONE     = 2'd3
    } event_kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BRIGHTNESS_MAX   = 2'd0,
        CFG_STEP_SECONDS     = 2'd1,
        CFG_SHUTDOWN_SECONDS = 2'd2,
        CFG_TICKS_PER_SECOND = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [7:0]  BRIGHTNESS_MAX_RST   = 8'd12;
    localparam logic [7:0]  STEP_SECONDS_RST     = 8'd5;
    localparam logic [15:0] SHUTDOWN_SECONDS_RST = 16'd3600;
    localparam logic [7:0]  TICKS_PER_SECOND_RST = 8'd60;

    // Lamp state carried from one event to the next.
    typedef struct packed {
        logic        active;
        logic [7:0]  line_ticks;
        logic [15:0] seconds;
        logic [7:0]  brightness;
        logic [7:0]  phase;
        logic        last_button;
        logic        last_alarm;
        logic        led;
    } lamp_state_t;

endpackage

// File: src/srld_req_if.sv
interface srld_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       stop_button;
    logic       alarm_level;

    modport source (output valid, output req_type, output stop_button,
                    output alarm_level, input ready);
    modport sink (input valid, input req_type, input stop_button,
                  input alarm_level, output ready);
endinterface

// File: src/srld_res_if.sv
interface srld_res_if;
    logic       valid;
    logic       ready;
    logic       led_drive;
    logic       lamp_active;
    logic [7:0] brightness_level;

    modport source (output valid, output led_drive, output lamp_active,
                    output brightness_level, input ready);
    modport sink (input valid, input led_drive, input lamp_active,
                  input brightness_level, output ready);
endinterface

// File: src/sunrise_led_ramp_dimmer.sv
// An accepted event beat is held in the input register; its result beat is valid
// once it moves on into the result register, which stalls while res.ready is low.
// One event per clock while res.ready is high; lamp state logic is combinational.
// Reset (rst_n low, asynchronous): lamp off, all counters cleared, registers
// back to brightness_max 12, step_seconds 5, shutdown_seconds 3600, ticks 60.
module sunrise_led_ramp_dimmer
    import srld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    srld_req_if.sink              req,
    srld_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [7:0]  brightness_max_reg;
    logic [7:0]  step_seconds_reg;
    logic [15:0] shutdown_seconds_reg;
    logic [7:0]  ticks_per_second_reg;

    logic        in_valid_reg;
    event_kind_t in_kind_reg;
    logic        in_button_reg;
    logic        in_alarm_reg;

    lamp_state_t state_reg;
    lamp_state_t state_next;

    logic        out_valid_reg;
    logic        out_led_reg;
    logic        out_active_reg;
    logic [7:0]  out_bright_reg;

    logic        advance;
    logic [7:0]  ticks_inc;
    logic [7:0]  phase_inc;

    // The result stage moves whenever its register is free or being drained.
    assign advance   = !out_valid_reg || res.ready;
    assign req.ready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_max_reg   <= BRIGHTNESS_MAX_RST;
            step_seconds_reg     <= STEP_SECONDS_RST;
            shutdown_seconds_reg <= SHUTDOWN_SECONDS_RST;
            ticks_per_second_reg <= TICKS_PER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BRIGHTNESS_MAX:   brightness_max_reg   <= cfg_data[7:0];
                CFG_STEP_SECONDS:     step_seconds_reg     <= cfg_data[7:0];
                CFG_SHUTDOWN_SECONDS: shutdown_seconds_reg <= cfg_data[15:0];
                CFG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg   <= event_kind_t'(req.req_type);
            in_button_reg <= req.stop_button;
            in_alarm_reg  <= req.alarm_level;
        end
    end

    assign ticks_inc = state_reg.line_ticks + 8'd1;
    assign phase_inc = state_reg.phase + 8'd1;

    // Event handling followed by the shutdown and lamp-off checks.
    always_comb
    begin
        state_next = state_reg;
        unique case (in_kind_reg)
            EV_LINE:
            begin
                if (state_reg.active)
                begin
                    state_next.line_ticks = ticks_inc;
                    if (ticks_inc == ticks_per_second_reg)
                    begin
                        state_next.line_ticks = 8'd0;
                        state_next.seconds    = state_reg.seconds + 16'd1;
                    end
                    if (state_next.seconds == {8'd0, step_seconds_reg} &&
                        state_reg.brightness < brightness_max_reg)
                    begin
                        state_next.brightness = state_reg.brightness + 8'd1;
                        state_next.seconds    = 16'd0;
                    end
                end
            end
            EV_DEBOUNCE:
            begin
                if (!state_reg.last_button && !in_button_reg)
                begin
                    state_next.active = 1'b0;
                end
                if (state_reg.last_alarm && in_alarm_reg)
                begin
                    state_next.active = 1'b1;
                end
                state_next.last_button = in_button_reg;
                state_next.last_alarm  = in_alarm_reg;
            end
            EV_PWM:
            begin
                if (state_reg.active)
                begin
                    state_next.phase = phase_inc;
                    if (phase_inc >= state_reg.brightness)
                    begin
                        state_next.led = 1'b0;
                    end
                    if (phase_inc == brightness_max_reg)
                    begin
                        state_next.led   = 1'b1;
                        state_next.phase = 8'd0;
                    end
                end
            end
            default: ;
        endcase

        if (state_next.seconds >= shutdown_seconds_reg)
        begin
            state_next.active  = 1'b0;
            state_next.seconds = 16'd0;
        end
        if (!state_next.active)
        begin
            state_next.led        = 1'b0;
            state_next.seconds    = 16'd0;
            state_next.brightness = 8'd0;
        end
    end

    // Lamp state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_led_reg    <= state_next.led;
            out_active_reg <= state_next.active;
            out_bright_reg <= state_next.brightness;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.led_drive        = out_led_reg;
    assign res.lamp_active      = out_active_reg;
    assign res.brightness_level = out_bright_reg;

endmodule

// File: tb/sunrise_led_ramp_dimmer_tb.sv
`timescale 1ns / 100ps

module sunrise_led_ramp_dimmer_tb;
    import srld_pkg::*;

    // One result beat as the lamp controller reports it.
    typedef struct packed {
        logic       led;
        logic       active;
        logic [7:0] level;
    } lamp_result_t;

    // One line of the directed plan: either a register write or an event beat.
    typedef struct {
        bit           is_cfg;
        cfg_index_t   reg_idx;
        logic [15:0]  reg_val;
        event_kind_t  kind;
        logic         btn;
        logic         alm;
        bit           typed;
        lamp_result_t want;
    } plan_row_t;

    localparam int PLAN_LEN = 31;
    localparam int PHASES = 6;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srld_req_if req_bus ();
    srld_res_if res_bus ();

    sunrise_led_ramp_dimmer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the lamp state and its registers.
    lamp_state_t  lamp;
    logic [7:0]   max_steps;
    logic [7:0]   step_secs;
    logic [15:0]  shut_secs;
    logic [7:0]   tick_rate;

    lamp_result_t lamp_expect_q[$];
    lamp_result_t want_beat;
    lamp_result_t got_beat;

    int  mismatches = 0;
    int  results_seen = 0;
    int  events_sent = 0;
    int  timer_offs = 0;
    int  peak_level = 0;
    bit  steady = 1'b0;

    plan_row_t plan [0:PLAN_LEN-1];

    // Random phases: register settings, length and share of line ticks.
    int ph_max   [PHASES] = '{4, 8, 6, 0, 255, 3};
    int ph_step  [PHASES] = '{1, 2, 1, 1, 1, 1};
    int ph_shut  [PHASES] = '{20, 40, 65535, 500, 200, 6};
    int ph_rate  [PHASES] = '{2, 3, 0, 4, 1, 1};
    int ph_len   [PHASES] = '{200, 200, 300, 300, 250, 200};
    int ph_line  [PHASES] = '{50, 50, 80, 15, 50, 50};

    // Clock with a 20 ns period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Runaway guard.
    initial
    begin
        #4000000;
        $display("sunrise_led_ramp_dimmer_tb NOT OK");
        $finish;
    end

    // Result side stalls about 9 times in a hundred, never during a steady stretch.
    always @(negedge clk)
    begin
        res_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 9);
    end

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("mismatch at result %0d: %s expected %0d, got %0d",
                 results_seen, what, want, got);
        mismatches++;
    endtask

    // Compare every accepted result beat with the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got_beat = '{res_bus.led_drive, res_bus.lamp_active, res_bus.brightness_level};
            if (lamp_expect_q.size() == 0)
            begin
                flag_mismatch("result beat with nothing pending", 0, 1);
            end
            else
            begin
                want_beat = lamp_expect_q.pop_front();
                if (got_beat.led !== want_beat.led)
                    flag_mismatch("led_drive", int'(want_beat.led), int'(got_beat.led));
                if (got_beat.active !== want_beat.active)
                    flag_mismatch("lamp_active", int'(want_beat.active),
                                  int'(got_beat.active));
                if (got_beat.level !== want_beat.level)
                    flag_mismatch("brightness_level", int'(want_beat.level),
                                  int'(got_beat.level));
            end
            results_seen++;
        end
    end

    // Lamp behavior for one event, followed by the background check.
    function automatic lamp_result_t advance_lamp(input event_kind_t kind, input logic btn,
                                                  input logic alm);
        case (kind)
            EV_LINE:
            begin
                if (lamp.active)
                begin
                    lamp.line_ticks = lamp.line_ticks + 8'd1;
                    if (lamp.line_ticks == tick_rate)
                    begin
                        lamp.line_ticks = 8'd0;
                        lamp.seconds = lamp.seconds + 16'd1;
                    end
                    if (lamp.seconds == {8'd0, step_secs} && lamp.brightness < max_steps)
                    begin
                        lamp.brightness = lamp.brightness + 8'd1;
                        lamp.seconds = 16'd0;
                    end
                end
            end
            EV_DEBOUNCE:
            begin
                // The alarm is applied last, so it wins over a stop on the same sample.
                if (!lamp.last_button && !btn)
                    lamp.active = 1'b0;
                if (lamp.last_alarm && alm)
                    lamp.active = 1'b1;
                lamp.last_button = btn;
                lamp.last_alarm = alm;
            end
            EV_PWM:
            begin
                if (lamp.active)
                begin
                    lamp.phase = lamp.phase + 8'd1;
                    if (lamp.phase >= lamp.brightness)
                        lamp.led = 1'b0;
                    if (lamp.phase == max_steps)
                    begin
                        lamp.led = 1'b1;
                        lamp.phase = 8'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (lamp.seconds >= shut_secs)
        begin
            if (lamp.active)
                timer_offs++;
            lamp.active = 1'b0;
            lamp.seconds = 16'd0;
        end
        if (!lamp.active)
        begin
            lamp.led = 1'b0;
            lamp.seconds = 16'd0;
            lamp.brightness = 8'd0;
        end
        if (int'(lamp.brightness) > peak_level)
            peak_level = int'(lamp.brightness);
        return '{lamp.led, lamp.active, lamp.brightness};
    endfunction

    // Drive one event beat from a falling edge and hold it until it is taken.
    // Valid stays high afterward, so the caller either sends again or drains.
    task automatic send_event(input event_kind_t kind, input logic btn, input logic alm,
                              input bit typed, input lamp_result_t want);
        lamp_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.stop_button <= btn;
        req_bus.alarm_level <= alm;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = advance_lamp(kind, btn, alm);
        lamp_expect_q.push_back(typed ? want : predicted);
        events_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        wait (lamp_expect_q.size() == 0);
        @(negedge clk);
    endtask

    // Register write, entered and left at a falling edge.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_BRIGHTNESS_MAX:   max_steps = val[7:0];
            CFG_STEP_SECONDS:     step_secs = val[7:0];
            CFG_SHUTDOWN_SECONDS: shut_secs = val;
            CFG_TICKS_PER_SECOND: tick_rate = val[7:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: switch the lamp on with two alarm samples,
    // then ramp with line and PWM ticks, with the odd button sample and noise.
    function automatic void pick_event(input int line_pct, output event_kind_t kind,
                                       output logic btn, output logic alm);
        int roll;
        roll = $urandom_range(0, 99);
        btn = 1'b1;
        alm = 1'b0;
        if (roll < 8)
        begin
            kind = event_kind_t'($urandom_range(0, 3));
            btn = 1'($urandom_range(0, 1));
            alm = 1'($urandom_range(0, 1));
        end
        else if (!lamp.active)
        begin
            kind = EV_DEBOUNCE;
            alm = 1'b1;
        end
        else if (roll < 14)
        begin
            kind = EV_DEBOUNCE;
            btn = 1'($urandom_range(0, 1));
            alm = ($urandom_range(0, 3) == 0);
        end
        else if ($urandom_range(0, 99) < line_pct)
        begin
            kind = EV_LINE;
        end
        else
        begin
            kind = EV_PWM;
        end
    endfunction

    function automatic plan_row_t cfg_row(input cfg_index_t idx, input logic [15:0] val);
        plan_row_t r;
        r = '{1'b1, idx, val, EV_NONE, 1'b0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic plan_row_t ev_row(input event_kind_t kind, input logic btn,
                                         input logic alm);
        plan_row_t r;
        r = '{1'b0, CFG_BRIGHTNESS_MAX, 16'd0, kind, btn, alm, 1'b0, '0};
        return r;
    endfunction

    function automatic plan_row_t typed_row(input event_kind_t kind, input logic btn,
                                            input logic alm, input logic led,
                                            input logic act, input logic [7:0] lvl);
        plan_row_t r;
        r = '{1'b0, CFG_BRIGHTNESS_MAX, 16'd0, kind, btn, alm, 1'b1, '{led, act, lvl}};
        return r;
    endfunction

    initial
    begin
        event_kind_t kind;
        logic btn;
        logic alm;

        // Every input known from time zero.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = EV_LINE;
        req_bus.stop_button = 1'b1;
        req_bus.alarm_level = 1'b0;
        res_bus.ready = 1'b0;

        lamp = '0;
        max_steps = BRIGHTNESS_MAX_RST;
        step_secs = STEP_SECONDS_RST;
        shut_secs = SHUTDOWN_SECONDS_RST;
        tick_rate = TICKS_PER_SECOND_RST;

        plan = '{
            // Reset settings: a single low button sample does not stop the lamp; two in a row do.
            typed_row(EV_DEBOUNCE, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0),
            typed_row(EV_NONE,     1'b1, 1'b1, 1'b0, 1'b0, 8'd0),
            typed_row(EV_DEBOUNCE, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0),
            typed_row(EV_DEBOUNCE, 1'b1, 1'b1, 1'b0, 1'b1, 8'd0),
            typed_row(EV_DEBOUNCE, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0),
            // Stop and alarm on the same sample: the alarm wins.
            typed_row(EV_DEBOUNCE, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0),
            typed_row(EV_DEBOUNCE, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0),
            typed_row(EV_PWM,      1'b0, 1'b0, 1'b0, 1'b0, 8'd0),
            // Fast ramp: one tick per second, one second per step, two steps.
            cfg_row(CFG_BRIGHTNESS_MAX, 16'd2),
            cfg_row(CFG_STEP_SECONDS, 16'd1),
            cfg_row(CFG_TICKS_PER_SECOND, 16'd1),
            cfg_row(CFG_SHUTDOWN_SECONDS, 16'd3),
            typed_row(EV_DEBOUNCE, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0),
            typed_row(EV_DEBOUNCE, 1'b1, 1'b1, 1'b0, 1'b1, 8'd0),
            typed_row(EV_LINE,     1'b0, 1'b0, 1'b0, 1'b1, 8'd1),
            typed_row(EV_LINE,     1'b0, 1'b0, 1'b0, 1'b1, 8'd2),
            ev_row(EV_PWM, 1'b0, 1'b0),
            ev_row(EV_PWM, 1'b0, 1'b0),
            ev_row(EV_PWM, 1'b0, 1'b0),
            // Maximum lowered below the current brightness.
            cfg_row(CFG_BRIGHTNESS_MAX, 16'd1),
            ev_row(EV_LINE, 1'b0, 1'b0),
            ev_row(EV_PWM, 1'b0, 1'b0),
            ev_row(EV_LINE, 1'b0, 1'b0),
            // Third second at full brightness: timed switch-off.
            typed_row(EV_LINE,     1'b0, 1'b0, 1'b0, 1'b0, 8'd0),
            // Zero shutdown time keeps the lamp off; other registers at their top.
            cfg_row(CFG_SHUTDOWN_SECONDS, 16'd0),
            cfg_row(CFG_BRIGHTNESS_MAX, 16'd255),
            cfg_row(CFG_STEP_SECONDS, 16'd255),
            cfg_row(CFG_TICKS_PER_SECOND, 16'd255),
            typed_row(EV_DEBOUNCE, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0),
            typed_row(EV_LINE,     1'b0, 1'b0, 1'b0, 1'b0, 8'd0),
            typed_row(EV_NONE,     1'b0, 1'b0, 1'b0, 1'b0, 8'd0)
        };

        // Reset held from time zero, released on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed plan.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].is_cfg)
            begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_event(plan[i].kind, plan[i].btn, plan[i].alm, plan[i].typed,
                           plan[i].want);
            end
        end

        // Random phases, each under its own register settings.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_reg(CFG_BRIGHTNESS_MAX, 16'(ph_max[p]));
            write_reg(CFG_STEP_SECONDS, 16'(ph_step[p]));
            write_reg(CFG_SHUTDOWN_SECONDS, 16'(ph_shut[p]));
            write_reg(CFG_TICKS_PER_SECOND, 16'(ph_rate[p]));
            steady = (p == 4);
            for (int n = 0; n < ph_len[p]; n++)
            begin
                // Hold off in mid-phase until every result has been returned.
                if (p == 1 && n == 100)
                    drain_results();
                pick_event(ph_line[p], kind, btn, alm);
                send_event(kind, btn, alm, 1'b0, '0);
            end
            steady = 1'b0;
        end

        // Let the last results through, then idle so that stray beats are still checked.
        drain_results();
        repeat (8) @(posedge clk);

        $display("Ran %0d events over %0d register settings, %0d results compared.",
                 events_sent, PHASES + 4, results_seen);
        $display("Lamp reached brightness %0d and was switched off by the timer %0d times.",
                 peak_level, timer_offs);
        if (mismatches == 0 && lamp_expect_q.size() == 0)
            $display("sunrise_led_ramp_dimmer_tb OK");
        else
            $display("sunrise_led_ramp_dimmer_tb NOT OK");
        $finish;
    end

endmodule

// File: sunrise_led_ramp_dimmer.f
src/srld_pkg.sv
src/srld_req_if.sv
src/srld_res_if.sv
src/sunrise_led_ramp_dimmer.sv
tb/sunrise_led_ramp_dimmer_tb.sv
